>>> src/hsv_pkg.sv
// Package for the HSV saturation adjust block.
// Holds the word structs, fixed widths and constants; no dependencies.
package hsv_pkg;

	localparam int CHAN_BITS   = 8;
	localparam int FACTOR_W    = 12;
	localparam int FACTOR_FRAC = 8;
	localparam int SAT_FRAC    = 16;

	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 12'd256;

	// first divide: saturation quotient, one bit past unity
	localparam int Q1_BITS = SAT_FRAC + 1;
	localparam int N1_W    = CHAN_BITS + FACTOR_W + FACTOR_FRAC;
	// chroma and per-channel interpolation divide
	localparam int CQ_W    = CHAN_BITS + SAT_FRAC;
	localparam int Q2_BITS = CQ_W;
	localparam int N2_W    = CQ_W + CHAN_BITS;

	typedef logic [CHAN_BITS-1:0] chan_t;

	typedef struct packed {
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} pixel_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} result_t;

	// classified word handed from front to back
	typedef struct packed {
		logic  gray;
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t mx;
		chan_t mn;
		chan_t delta;
	} work_t;

	localparam int WORK_W = $bits(work_t);
	localparam int RES_W  = $bits(result_t);

endpackage

>>> src/hsv_fifo.sv
// Small register queue used between front and back and on the result side.
// No package dependencies.
module hsv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

>>> src/hsv_front.sv
// Front end: takes pixels, finds max, min, spread and flags gray ones.
// Depends on hsv_pkg.
module hsv_front
	import hsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  pixel_t pixel,
	output logic   full,
	output logic   word_valid,
	output work_t  word,
	input  logic   word_full
);
	logic  valid_s1;
	work_t word_s1;
	work_t nxt;
	logic  load;
	chan_t mx, mn;

	always_comb begin
		mx = pixel.red_in;
		mn = pixel.red_in;
		if (pixel.green_in > mx) mx = pixel.green_in;
		if (pixel.blue_in > mx) mx = pixel.blue_in;
		if (pixel.green_in < mn) mn = pixel.green_in;
		if (pixel.blue_in < mn) mn = pixel.blue_in;
		nxt.r     = pixel.red_in;
		nxt.g     = pixel.green_in;
		nxt.b     = pixel.blue_in;
		nxt.mx    = mx;
		nxt.mn    = mn;
		nxt.delta = mx - mn;
		nxt.gray  = (mx == mn);
	end

	// advance when the stage is empty or its word leaves this cycle
	assign load       = !valid_s1 || !word_full;
	assign full       = !load;
	assign word_valid = valid_s1;
	assign word       = word_s1;

	always_ff @(posedge clk) begin
		if (load && push) begin
			word_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= push;
		end
	end
endmodule

>>> src/hsv_back.sv
// Back end: saturation divide, chroma multiply, per-channel interpolation
// divide and rebuild, one quotient bit per stage. Depends on hsv_pkg.
module hsv_back
	import hsv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FACTOR_W-1:0] factor,
	input  logic                word_empty,
	input  work_t               word,
	output logic                word_pop,
	output logic                res_valid,
	output result_t             res,
	input  logic                res_full
);
	localparam int S_CQ   = Q1_BITS + 1;
	localparam int S_PROD = S_CQ + 1;
	localparam int S_FIN  = S_PROD + Q2_BITS + 1;

	typedef struct packed {
		work_t                   w;
		logic                    ovf;
		logic [N1_W-1:0]         rem1;
		logic [Q1_BITS-1:0]      q1;
		logic [CQ_W-1:0]         cq;
		logic [2:0][N2_W-1:0]    rem2;
		logic [2:0][Q2_BITS-1:0] q2;
		result_t                 res;
	} bk_t;

	bk_t  pipe_q  [S_FIN+1];
	bk_t  nxt     [S_FIN+1];
	logic valid_q [S_FIN+1];
	logic adv;

	// stall the whole line only when the last word cannot leave
	assign adv       = !(valid_q[S_FIN] && res_full);
	assign word_pop  = adv && !word_empty;
	assign res_valid = valid_q[S_FIN];
	assign res       = pipe_q[S_FIN].res;

	always_comb begin
		logic [N1_W-1:0] prod;
		nxt[0]      = '0;
		nxt[0].w    = word;
		prod        = N1_W'(word.delta) * N1_W'(factor);
		nxt[0].rem1 = prod << FACTOR_FRAC;
		nxt[0].ovf  = (nxt[0].rem1 >= (N1_W'(word.mx) << Q1_BITS));
	end

	genvar k;
	for (k = 1; k <= S_FIN; k++) begin : g_stage
		if (k <= Q1_BITS) begin : g_div1
			localparam int J = Q1_BITS - k;
			always_comb begin
				logic [N1_W-1:0] dv;
				nxt[k] = pipe_q[k-1];
				dv     = N1_W'(pipe_q[k-1].w.mx) << J;
				if (pipe_q[k-1].rem1 >= dv) begin
					nxt[k].rem1  = pipe_q[k-1].rem1 - dv;
					nxt[k].q1[J] = 1'b1;
				end
			end
		end else if (k == S_CQ) begin : g_cq
			always_comb begin
				logic [Q1_BITS-1:0] sq;
				nxt[k] = pipe_q[k-1];
				sq     = pipe_q[k-1].q1;
				// clamp saturation to one
				if (pipe_q[k-1].ovf || sq > (Q1_BITS'(1) << SAT_FRAC)) begin
					sq = Q1_BITS'(1) << SAT_FRAC;
				end
				nxt[k].cq = CQ_W'(CQ_W'(pipe_q[k-1].w.mx) * CQ_W'(sq));
			end
		end else if (k == S_PROD) begin : g_prod
			always_comb begin
				bk_t p;
				p      = pipe_q[k-1];
				nxt[k] = p;
				nxt[k].rem2[0] = N2_W'(p.cq) * N2_W'(chan_t'(p.w.r - p.w.mn));
				nxt[k].rem2[1] = N2_W'(p.cq) * N2_W'(chan_t'(p.w.g - p.w.mn));
				nxt[k].rem2[2] = N2_W'(p.cq) * N2_W'(chan_t'(p.w.b - p.w.mn));
			end
		end else if (k < S_FIN) begin : g_div2
			localparam int J = S_FIN - 1 - k;
			always_comb begin
				logic [N2_W-1:0] dv;
				nxt[k] = pipe_q[k-1];
				dv     = N2_W'(pipe_q[k-1].w.delta) << J;
				for (int c = 0; c < 3; c++) begin
					if (pipe_q[k-1].rem2[c] >= dv) begin
						nxt[k].rem2[c]  = pipe_q[k-1].rem2[c] - dv;
						nxt[k].q2[c][J] = 1'b1;
					end
				end
			end
		end else begin : g_fin
			always_comb begin
				logic [CQ_W-1:0]   base;
				logic [CQ_W:0]     sum;
				logic [2:0]        [CHAN_BITS-1:0] ch;
				bk_t               p;
				p    = pipe_q[k-1];
				base = (CQ_W'(p.w.mx) << SAT_FRAC) - p.cq;
				for (int c = 0; c < 3; c++) begin
					sum = {1'b0, base} + {1'b0, p.q2[c]};
					if ((sum >> SAT_FRAC) > (CQ_W+1)'({CHAN_BITS{1'b1}})) begin
						ch[c] = '1;
					end else begin
						ch[c] = sum[SAT_FRAC +: CHAN_BITS];
					end
				end
				nxt[k] = p;
				if (p.w.gray) begin
					nxt[k].res = '{red_out: p.w.r, green_out: p.w.g, blue_out: p.w.b};
				end else begin
					nxt[k].res = '{red_out: ch[0], green_out: ch[1], blue_out: ch[2]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s <= S_FIN; s++) begin
				pipe_q[s] <= nxt[s];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= S_FIN; s++) begin
				valid_q[s] <= 1'b0;
			end
		end else if (adv) begin
			valid_q[0] <= !word_empty;
			for (int s = 1; s <= S_FIN; s++) begin
				valid_q[s] <= valid_q[s-1];
			end
		end
	end
endmodule

>>> src/hsv_saturation_adjust_top.sv
// Top level of the HSV saturation adjust block.
// Depends on hsv_pkg, hsv_fifo, hsv_front and hsv_back.
//
// Pixels enter on a queue-style port: a word is taken when push is high and
// full is low. Results leave the same way: the oldest result sits on result
// while empty is low and is taken when pop is high.
// cfg_we writes cfg_data into the saturation factor (unsigned Q4.8, 256 is
// 1.0); write it only while no pixel is in flight.
// Throughput is one pixel per clock while the receiver keeps popping. From
// the accepting edge to empty falling, a pixel passes one classify stage, the
// middle queue, 45 back end stages (input stage, 17 saturation quotient bits,
// chroma, products, 24 interpolation quotient bits, rebuild) and the result
// queue write.
// Reset clears every queue and pipeline valid flag and loads the factor
// with 1.0. When the receiver stops popping, the result queue fills, the
// back end holds, the middle queue fills, and full rises; no word is lost.
module hsv_saturation_adjust_top
	import hsv_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pixel_t              pixel,
	input  logic                pop,
	output logic                empty,
	output result_t             result,
	input  logic                cfg_we,
	input  logic [FACTOR_W-1:0] cfg_data
);
	logic [FACTOR_W-1:0] factor_q;
	logic                f_valid, mid_full, mid_empty, mid_pop;
	work_t               f_word;
	logic [WORK_W-1:0]   mid_rdata;
	logic                res_valid, res_full;
	result_t             res;
	logic [RES_W-1:0]    out_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_ONE;
		end else if (cfg_we) begin
			factor_q <= cfg_data;
		end
	end

	hsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pixel      (pixel),
		.full       (full),
		.word_valid (f_valid),
		.word       (f_word),
		.word_full  (mid_full)
	);

	hsv_fifo #(.WIDTH(WORK_W), .DEPTH(MID_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_word),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	hsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.factor     (factor_q),
		.word_empty (mid_empty),
		.word       (work_t'(mid_rdata)),
		.word_pop   (mid_pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_full   (res_full)
	);

	hsv_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = result_t'(out_rdata);
endmodule
